FILE: src/m3i_pkg.sv
// Shared widths, types and the cofactor index table of the 3x3 inverse pipeline.
package m3i_pkg;

  localparam int ELEM_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int PW = 2 * ELEM_WIDTH;
  localparam int CW = 2 * ELEM_WIDTH + 1;
  localparam int DW = 3 * ELEM_WIDTH + 3;

  localparam int COF_LAT  = 2;
  localparam int DET_LAT  = 5;
  localparam int C_DLY    = DET_LAT;
  localparam int DIV_LAT  = ELEM_WIDTH + 4;
  localparam int PIPE_LAT = COF_LAT + DET_LAT + DIV_LAT;

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;
  typedef logic signed [PW-1:0]         prod_t;
  typedef logic signed [CW-1:0]         cof_t;
  typedef logic        [ELEM_WIDTH-1:0] mag_t;

  typedef struct packed {
    elem_t det;
    mag_t  dmag;
    logic  dneg;
  } det_info_t;

  typedef int cof_idx_t [9][4];
  localparam cof_idx_t COF_IDX = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};

endpackage

FILE: src/m3i_cof.sv
// One cofactor lane: two registered products and their registered difference.
module m3i_cof (
  input  logic           clk,
  input  logic           en,
  input  m3i_pkg::elem_t x,
  input  m3i_pkg::elem_t y,
  input  m3i_pkg::elem_t u,
  input  m3i_pkg::elem_t v,
  output m3i_pkg::cof_t  c
);
  import m3i_pkg::*;

  prod_t p1_r, p2_r;
  cof_t  c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= x * y;
      p2_r <= u * v;
      c_r  <= CW'(p1_r) - CW'(p2_r);
    end
  end

  assign c = c_r;

endmodule

FILE: src/m3i_det.sv
// Determinant merge: row 0 expansion, round, saturate and magnitude for the dividers.
module m3i_det (
  input  logic                clk,
  input  logic                en,
  input  m3i_pkg::elem_t      a0,
  input  m3i_pkg::elem_t      a1,
  input  m3i_pkg::elem_t      a2,
  input  m3i_pkg::cof_t       c0,
  input  m3i_pkg::cof_t       c3,
  input  m3i_pkg::cof_t       c6,
  output m3i_pkg::det_info_t  info
);
  import m3i_pkg::*;

  localparam logic [DW:0] RND = (DW+1)'(1) << (2 * FRAC_BITS - 1);
  localparam logic [DW:0] LIM = (DW+1)'(1) << (ELEM_WIDTH - 1);

  elem_t a_dly_r [3][COF_LAT];
  logic signed [CW-1:0] lo_r [3];
  logic signed [CW-1:0] hi_r [3];
  logic signed [DW-1:0] t_r [3];
  logic signed [DW-1:0] dsum_r;
  logic        [DW-1:0] mag_r;
  logic                 neg_r;
  det_info_t            info_r;

  elem_t av [3];
  cof_t  cv [3];
  logic [DW:0] sh;
  logic [DW:0] smag;
  mag_t        dmag_nxt;

  assign cv[0] = c0;
  assign cv[1] = c3;
  assign cv[2] = c6;

  always_ff @(posedge clk) begin
    if (en) begin
      a_dly_r[0][0] <= a0;
      a_dly_r[1][0] <= a1;
      a_dly_r[2][0] <= a2;
      for (int k = 0; k < 3; k++) begin
        for (int s = 1; s < COF_LAT; s++) a_dly_r[k][s] <= a_dly_r[k][s-1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) av[k] = a_dly_r[k][COF_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        lo_r[k] <= av[k] * $signed({1'b0, cv[k][ELEM_WIDTH-1:0]});
        hi_r[k] <= av[k] * $signed(cv[k][CW-1:ELEM_WIDTH]);
        t_r[k]  <= (DW'(hi_r[k]) <<< ELEM_WIDTH) + DW'(lo_r[k]);
      end
      dsum_r <= t_r[0] + t_r[1] + t_r[2];
      neg_r  <= dsum_r[DW-1];
      mag_r  <= dsum_r[DW-1] ? DW'(-dsum_r) : DW'(dsum_r);
      info_r.dmag <= dmag_nxt;
      info_r.dneg <= neg_r && (dmag_nxt != '0);
      info_r.det  <= neg_r ? elem_t'(-{1'b0, dmag_nxt}) : elem_t'(dmag_nxt);
    end
  end

  always_comb begin
    sh = ({1'b0, mag_r} + RND) >> (2 * FRAC_BITS);
    if (neg_r) smag = (sh > LIM) ? LIM : sh;
    else       smag = (sh > LIM - 1'b1) ? LIM - 1'b1 : sh;
    dmag_nxt = smag[ELEM_WIDTH-1:0];
  end

  assign info = info_r;

endmodule

FILE: src/m3i_div.sv
// One divider lane: rounded cofactor over determinant, one quotient bit per stage.
module m3i_div (
  input  logic               clk,
  input  logic               en,
  input  m3i_pkg::cof_t      c,
  input  m3i_pkg::det_info_t info,
  output m3i_pkg::elem_t     q
);
  import m3i_pkg::*;

  localparam int W = ELEM_WIDTH;
  localparam logic [W-1:0] LIM = W'(1) << (W - 1);

  logic [CW-1:0] cm_r;
  logic          sneg1_r, sneg2_r;
  mag_t          d_r;
  logic [CW:0]   num_r;
  logic [W:0]    dd2_r;

  logic [W:0]   rem_r [W+1];
  logic [W-1:0] low_r [W+1];
  logic [W:0]   dd_r  [W+1];
  logic         ovf_r [W+1];
  logic         sn_r  [W+1];
  elem_t        q_r;

  logic [W+1:0] t   [W];
  logic         ge  [W];

  always_ff @(posedge clk) begin
    if (en) begin
      sneg1_r <= c[CW-1] ^ info.dneg;
      cm_r    <= c[CW-1] ? CW'(-c) : CW'(c);
      d_r     <= info.dmag;
      sneg2_r <= sneg1_r;
      num_r   <= {cm_r, 1'b0} + (CW+1)'(d_r);
      dd2_r   <= {d_r, 1'b0};
      ovf_r[0] <= num_r >= ((CW+1)'(dd2_r) << W);
      rem_r[0] <= num_r[2*W:W];
      low_r[0] <= num_r[W-1:0];
      dd_r[0]  <= dd2_r;
      sn_r[0]  <= sneg2_r;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_step
    assign t[k]  = {rem_r[k], low_r[k][W-1]};
    assign ge[k] = t[k] >= {1'b0, dd_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge[k] ? (W+1)'(t[k] - {1'b0, dd_r[k]}) : t[k][W:0];
        low_r[k+1] <= {low_r[k][W-2:0], ge[k]};
        dd_r[k+1]  <= dd_r[k];
        ovf_r[k+1] <= ovf_r[k];
        sn_r[k+1]  <= sn_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sn_r[W]) begin
        q_r <= (ovf_r[W] || low_r[W] > LIM) ? elem_t'(LIM) : elem_t'(-low_r[W]);
      end else begin
        q_r <= (ovf_r[W] || low_r[W] > LIM - 1'b1) ? elem_t'(LIM - 1'b1) : elem_t'(low_r[W]);
      end
    end
  end

  assign q = q_r;

endmodule

FILE: src/matrix3_inverse.sv
// Top level of the 3x3 fixed-point matrix inverse: lanes, merge, delay lines and output word.
// One matrix word enters per cycle while the output is not stalled (Q16.16 elements at the
// default widths); its result passes through the cofactor products, the determinant expansion
// and rounding, and the nine divider lanes, which retire one quotient bit per stage, then the
// output register. The whole pipeline holds while a finished word waits stalled at the output.
module matrix3_inverse (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  m3i_pkg::elem_t in_a00,
  input  m3i_pkg::elem_t in_a01,
  input  m3i_pkg::elem_t in_a02,
  input  m3i_pkg::elem_t in_a10,
  input  m3i_pkg::elem_t in_a11,
  input  m3i_pkg::elem_t in_a12,
  input  m3i_pkg::elem_t in_a20,
  input  m3i_pkg::elem_t in_a21,
  input  m3i_pkg::elem_t in_a22,
  output logic           out_valid,
  input  logic           out_stall,
  output m3i_pkg::elem_t out_inv00,
  output m3i_pkg::elem_t out_inv01,
  output m3i_pkg::elem_t out_inv02,
  output m3i_pkg::elem_t out_inv10,
  output m3i_pkg::elem_t out_inv11,
  output m3i_pkg::elem_t out_inv12,
  output m3i_pkg::elem_t out_inv20,
  output m3i_pkg::elem_t out_inv21,
  output m3i_pkg::elem_t out_inv22,
  output m3i_pkg::elem_t out_determinant,
  output logic           out_singular
);
  import m3i_pkg::*;

  logic          en;
  elem_t         a [9];
  cof_t          c [9];
  cof_t          c_dly_r [9][C_DLY];
  det_info_t     info;
  elem_t         q [9];
  elem_t         det_dly_r [DIV_LAT];
  logic [PIPE_LAT-1:0] v_r, v_nxt;
  logic          out_valid_r;
  elem_t         inv_r [9];
  elem_t         det_r;
  logic          sing_r;
  logic          sing;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign a[0] = in_a00; assign a[1] = in_a01; assign a[2] = in_a02;
  assign a[3] = in_a10; assign a[4] = in_a11; assign a[5] = in_a12;
  assign a[6] = in_a20; assign a[7] = in_a21; assign a[8] = in_a22;

  for (genvar i = 0; i < 9; i++) begin : g_lane
    m3i_cof u_cof (
      .clk (clk),
      .en  (en),
      .x   (a[COF_IDX[i][0]]),
      .y   (a[COF_IDX[i][1]]),
      .u   (a[COF_IDX[i][2]]),
      .v   (a[COF_IDX[i][3]]),
      .c   (c[i])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        c_dly_r[i][0] <= c[i];
        for (int s = 1; s < C_DLY; s++) c_dly_r[i][s] <= c_dly_r[i][s-1];
      end
    end

    m3i_div u_div (
      .clk  (clk),
      .en   (en),
      .c    (c_dly_r[i][C_DLY-1]),
      .info (info),
      .q    (q[i])
    );
  end

  m3i_det u_det (
    .clk  (clk),
    .en   (en),
    .a0   (a[0]),
    .a1   (a[1]),
    .a2   (a[2]),
    .c0   (c[0]),
    .c3   (c[3]),
    .c6   (c[6]),
    .info (info)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      det_dly_r[0] <= info.det;
      for (int s = 1; s < DIV_LAT; s++) det_dly_r[s] <= det_dly_r[s-1];
    end
  end

  assign v_nxt = {v_r[PIPE_LAT-2:0], in_valid};
  assign sing  = (det_dly_r[DIV_LAT-1] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= v_nxt;
      out_valid_r <= v_r[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) inv_r[i] <= sing ? '0 : q[i];
      det_r  <= det_dly_r[DIV_LAT-1];
      sing_r <= sing;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_inv00       = inv_r[0];
  assign out_inv01       = inv_r[1];
  assign out_inv02       = inv_r[2];
  assign out_inv10       = inv_r[3];
  assign out_inv11       = inv_r[4];
  assign out_inv12       = inv_r[5];
  assign out_inv20       = inv_r[6];
  assign out_inv21       = inv_r[7];
  assign out_inv22       = inv_r[8];
  assign out_determinant = det_r;
  assign out_singular    = sing_r;

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && sing_r |-> det_r == '0 && inv_r[0] == '0 && inv_r[4] == '0
      && inv_r[8] == '0)
    else $error("singular word carries nonzero fields");

  a_det_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !sing_r |-> det_r != '0)
    else $error("nonsingular word with zero determinant");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r) && $stable(det_r))
    else $error("pipeline advanced while output stalled");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> out_valid_r == $past(v_r[PIPE_LAT-1]))
    else $error("valid lost between last stage and output");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse pipeline.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import m3i_pkg::*;

  localparam int LATENCY = ELEM_WIDTH + 12;
  localparam int N_RANDOM = 1250;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    elem_t a [9];
  } matrix_t;

  typedef struct {
    elem_t inv [9];
    elem_t det;
    logic  sing;
  } inverse_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  elem_t in_a [9];
  logic  out_valid;
  logic  out_stall = 1'b0;
  elem_t out_inv [9];
  elem_t out_determinant;
  logic  out_singular;

  matrix_t  pending_words [$];
  inverse_t expected_inverses [$];
  int       errors = 0;
  longint   cycles = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       hold_off = 1'b0;
  bit       in_taken = 1'b0;

  initial for (int i = 0; i < 9; i++) in_a[i] = '0;

  matrix3_inverse dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a00(in_a[0]), .in_a01(in_a[1]), .in_a02(in_a[2]),
    .in_a10(in_a[3]), .in_a11(in_a[4]), .in_a12(in_a[5]),
    .in_a20(in_a[6]), .in_a21(in_a[7]), .in_a22(in_a[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_inv00(out_inv[0]), .out_inv01(out_inv[1]), .out_inv02(out_inv[2]),
    .out_inv10(out_inv[3]), .out_inv11(out_inv[4]), .out_inv12(out_inv[5]),
    .out_inv20(out_inv[6]), .out_inv21(out_inv[7]), .out_inv22(out_inv[8]),
    .out_determinant(out_determinant), .out_singular(out_singular)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [ELEM_WIDTH-1:0] saturate(logic signed [255:0] v);
    logic signed [255:0] hi;
    logic signed [255:0] lo;
    hi = (256'sd1 <<< (ELEM_WIDTH - 1)) - 1;
    lo = -(256'sd1 <<< (ELEM_WIDTH - 1));
    if (v > hi) return hi[ELEM_WIDTH-1:0];
    if (v < lo) return lo[ELEM_WIDTH-1:0];
    return v[ELEM_WIDTH-1:0];
  endfunction

  function automatic inverse_t invert(matrix_t m);
    inverse_t r;
    logic signed [255:0] x [9];
    logic signed [255:0] adj [9];
    logic signed [255:0] dsum, dmag, rounded, dv, cm, q;
    bit dneg, cneg;
    int k [9][4];
    k = '{'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
          '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
          '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};
    for (int i = 0; i < 9; i++) x[i] = m.a[i];
    for (int i = 0; i < 9; i++)
      adj[i] = x[k[i][0]] * x[k[i][1]] - x[k[i][2]] * x[k[i][3]];
    dsum = x[0] * adj[0] + x[1] * adj[3] + x[2] * adj[6];
    dneg = dsum < 0;
    dmag = dneg ? -dsum : dsum;
    rounded = (dmag + (256'sd1 <<< (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
    r.det = saturate(dneg ? -rounded : rounded);
    r.sing = (r.det == 0);
    for (int i = 0; i < 9; i++) r.inv[i] = '0;
    if (!r.sing) begin
      dv = r.det;
      dneg = dv < 0;
      dmag = dneg ? -dv : dv;
      for (int i = 0; i < 9; i++) begin
        cneg = adj[i] < 0;
        cm = cneg ? -adj[i] : adj[i];
        q = (2 * cm + dmag) / (2 * dmag);
        r.inv[i] = saturate((cneg != dneg) ? -q : q);
      end
    end
    return r;
  endfunction

  function automatic elem_t pick_elem();
    unique case ($urandom_range(0, 9))
      0: return elem_t'($urandom);
      1: return elem_t'({{ELEM_WIDTH{1'b0}}, 32'h7fffffff});
      2: return elem_t'(32'h80000000);
      3: return '0;
      4: return elem_t'(32'sd1 <<< FRAC_BITS) * ($urandom_range(0, 1) ? 1 : -1);
      5: return elem_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
      default: return elem_t'($signed($urandom_range(0, 32'h7ffffff)) - 32'sh3ffffff);
    endcase
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    int mode;
    for (int i = 0; i < 9; i++) m.a[i] = pick_elem();
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      for (int i = 0; i < 3; i++) m.a[6 + i] = m.a[3 + i];
    end else if (mode <= 3) begin
      for (int i = 0; i < 9; i++)
        m.a[i] = (i % 4 == 0) ? elem_t'($signed($urandom_range(1, 32'h7ffff)))
                              : elem_t'($signed($urandom_range(0, 32'h3fff)) - 32'sh1fff);
    end
    return m;
  endfunction

  function automatic matrix_t diag(elem_t d0, elem_t d1, elem_t d2);
    matrix_t m;
    for (int i = 0; i < 9; i++) m.a[i] = '0;
    m.a[0] = d0;
    m.a[4] = d1;
    m.a[8] = d2;
    return m;
  endfunction

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_taken) void'(pending_words.pop_front());
      if (pending_words.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
        in_valid <= 1'b1;
        in_a <= pending_words[0].a;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= hold_off || ($urandom_range(1, 100) <= recv_stall_pct);
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      matrix_t m;
      m.a = in_a;
      expected_inverses.push_back(invert(m));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_inverses.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
      end else begin
        inverse_t e;
        e = expected_inverses.pop_front();
        for (int i = 0; i < 9; i++)
          if (out_inv[i] !== e.inv[i]) begin
            $error("inv%0d%0d expected %0d got %0d", i / 3, i % 3, e.inv[i], out_inv[i]);
            errors++;
          end
        if (out_determinant !== e.det) begin
          $error("determinant expected %0d got %0d", e.det, out_determinant);
          errors++;
        end
        if (out_singular !== e.sing) begin
          $error("singular expected %0d got %0d", e.sing, out_singular);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    matrix_t m;
    int phase_pct [4][2];
    phase_pct = '{'{0, 0}, '{63, 0}, '{0, 63}, '{8, 8}};
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    pending_words.push_back(diag(32'sh10000, 32'sh10000, 32'sh10000));
    pending_words.push_back(diag(32'sh20000, -32'sh8000, 32'sh30000));
    pending_words.push_back(diag('0, 32'sh10000, 32'sh10000));
    pending_words.push_back(diag(32'sh1, 32'sh1, 32'sh1));
    pending_words.push_back(diag(32'sh100, 32'sh100, 32'sh100));
    pending_words.push_back(diag(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    pending_words.push_back(diag(32'sh80000000, 32'sh80000000, 32'sh80000000));
    pending_words.push_back(diag(32'sh80000000, 32'sh7fffffff, 32'sh10000));
    pending_words.push_back(diag(32'sh7fffffff, 32'sh1, 32'sh1));
    pending_words.push_back(diag(32'sh2, 32'sh8000, 32'sh8000));
    for (int i = 0; i < 9; i++) m.a[i] = elem_t'(32'sh10000 * (i + 1));
    pending_words.push_back(m);
    for (int i = 0; i < 9; i++) m.a[i] = '1;
    pending_words.push_back(m);
    for (int i = 0; i < 9; i++) m.a[i] = (i % 2) ? 32'sh7fffffff : 32'sh80000000;
    pending_words.push_back(m);
    m = diag(32'sh10000, 32'sh10000, 32'sh10000);
    m.a[1] = 32'sh3ffff;
    m.a[5] = -32'sh12345;
    m.a[6] = 32'sh8000;
    pending_words.push_back(m);
    m = diag('0, '0, '0);
    m.a[2] = 32'sh10000;
    m.a[4] = 32'sh18000;
    m.a[6] = -32'sh30000;
    pending_words.push_back(m);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_pct[p][0];
      recv_stall_pct = phase_pct[p][1];
      for (int i = 0; i < N_RANDOM / 4; i++) pending_words.push_back(random_matrix());
      if (p == 2) begin
        hold_off = 1'b1;
        repeat (3 * LATENCY) @(posedge clk);
        hold_off = 1'b0;
      end
      while (pending_words.size() > 0) @(posedge clk);
    end
    while (expected_inverses.size() > 0 || in_valid) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0 && expected_inverses.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
